// ===== src/fcds_pkg.sv =====
// Shared constants, configuration codes and item types for the divider select block.
package fcds_pkg;

  localparam int DivFracWidth = 12;
  localparam int RateWidth    = 36;
  localparam int DivWidth     = 2 * DivFracWidth;
  localparam int EffWidth     = $clog2(DivFracWidth + 1);

  localparam int CfgIdxWidth  = 2;
  localparam int CfgDataWidth = 4;

  localparam logic [CfgIdxWidth-1:0] CfgIntegerBits  = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CfgFractionBits = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CfgMashMode     = 2'd2;
  localparam logic [CfgIdxWidth-1:0] CfgLowJitter    = 2'd3;

  localparam logic ReqChoose = 1'b0;
  localparam logic ReqRate   = 1'b1;

  localparam logic StatusOk         = 1'b0;
  localparam logic StatusZeroTarget = 1'b1;

  typedef struct packed {
    logic                 req_type;
    logic [RateWidth-1:0] target_rate;
    logic [RateWidth-1:0] src_rate;
    logic                 ceil_en;
    logic [DivWidth-1:0]  divider_in;
  } req_t;

  typedef struct packed {
    logic [DivWidth-1:0]  divider;
    logic                 fraction_used;
    logic [RateWidth-1:0] achieved_rate;
    logic [RateWidth-1:0] jitter_metric;
    logic                 status;
  } rsp_t;

endpackage

// ===== src/fcds_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with saturation flag.
module fcds_div #(
  parameter int N_W = 48,
  parameter int D_W = 36,
  parameter int Q_W = 24
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [N_W-1:0] dividend_i,
  input  logic [D_W-1:0] divisor_i,
  output logic [Q_W-1:0] quot_o,
  output logic           sat_o,
  output logic           rem_nz_o
);

  logic [D_W-1:0] r_in [Q_W];
  logic [Q_W-1:0] q_in [Q_W];
  logic [D_W-1:0] d_in [Q_W];
  logic           s_in [Q_W];
  logic [D_W-1:0] r_q  [Q_W];
  logic [Q_W-1:0] q_q  [Q_W];
  logic [D_W-1:0] d_q  [Q_W];
  logic           s_q  [Q_W];

  // quotient overflows Q_W bits when the high dividend part reaches the divisor
  assign r_in[0] = D_W'(dividend_i >> Q_W);
  assign q_in[0] = dividend_i[Q_W-1:0];
  assign d_in[0] = divisor_i;
  assign s_in[0] = (dividend_i >> Q_W) >= {{(N_W-D_W){1'b0}}, divisor_i};

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic [D_W:0] t;
    logic [D_W:0] diff;
    logic         ge;

    if (k > 0) begin : g_link
      assign r_in[k] = r_q[k-1];
      assign q_in[k] = q_q[k-1];
      assign d_in[k] = d_q[k-1];
      assign s_in[k] = s_q[k-1];
    end

    assign t    = {r_in[k], q_in[k][Q_W-1]};
    assign ge   = t >= {1'b0, d_in[k]};
    assign diff = t - {1'b0, d_in[k]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k] <= ge ? diff[D_W-1:0] : t[D_W-1:0];
        q_q[k] <= {q_in[k][Q_W-2:0], ge};
        d_q[k] <= d_in[k];
        s_q[k] <= s_in[k];
      end
    end
  end

  assign quot_o   = q_q[Q_W-1];
  assign sat_o    = s_q[Q_W-1];
  assign rem_nz_o = r_q[Q_W-1] != '0;

endmodule

// ===== src/fractional_clock_divider_select_core.sv =====
// Top level: fractional clock divider selection and rate calculation pipeline.
//
// Input channel in_valid_i / in_stall_o / in_data_i carries one request item:
// a choose request (req_type 0) finds a 12.12 divider for a target rate, a rate
// request (req_type 1) turns divider_in into a rate. Every item gives exactly
// one result item on out_valid_o / out_stall_i / out_data_o.
// Configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_wdata_i); write
// it only while no item is in flight.
// The pipeline holds 24 stages of the divider quotient (one bit per stage),
// one round/clamp stage, 36 stages of the three parallel rate dividers (one
// bit per stage) and one output register. A new item enters every cycle unless
// the pipeline stalls; the bit-serial divider stages set the depth, not the rate.
// When the receiver stalls while a result waits, the whole pipeline holds and
// in_stall_o rises in the same cycle; nothing is dropped or repeated.
// Reset clears all valid bits and loads the configuration registers with 12, 12, 0, 0.
module fractional_clock_divider_select_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  fcds_pkg::req_t                      in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output fcds_pkg::rsp_t                      out_data_o,
  input  logic                                cfg_we_i,
  input  logic [fcds_pkg::CfgIdxWidth-1:0]    cfg_idx_i,
  input  logic [fcds_pkg::CfgDataWidth-1:0]   cfg_wdata_i
);
  import fcds_pkg::*;

  localparam int F  = DivFracWidth;
  localparam int RW = RateWidth;
  localparam int DW = DivWidth;
  localparam int NW = RW + F;
  localparam int QA = DW;
  localparam int QR = RW;
  localparam int EW = EffWidth;

  typedef struct packed {
    logic          choose;
    logic          ceil_en;
    logic          zero;
    logic [RW-1:0] parent;
    logic [DW-1:0] div_in;
  } a_t;

  typedef struct packed {
    logic [DW-1:0] div;
    logic          status;
    logic          jit_en;
    logic          both_zero;
    logic [RW-1:0] parent;
    logic [NW-1:0] dvd;
    logic [DW-1:0] d_avg;
    logic [DW-1:0] d_hi;
    logic [DW-1:0] d_lo;
  } b_t;

  typedef struct packed {
    logic [DW-1:0] div;
    logic          status;
    logic          jit_en;
    logic          both_zero;
    logic [RW-1:0] parent;
    logic          z_avg;
    logic          z_hi;
    logic          z_lo;
  } c_t;

  logic [CfgDataWidth-1:0] int_bits_q, frac_bits_q;
  logic                    mash_q, low_jit_q;
  logic [EW-1:0]           ib, fb, su;

  logic          en;
  logic [QA-1:0] a_vld_q;
  a_t            a_q [QA];
  a_t            a_in;
  logic          b_vld_q;
  b_t            b_q, b_d;
  logic [QR-1:0] c_vld_q;
  c_t            c_q [QR];
  logic          out_vld_q;
  rsp_t          out_q, out_d;

  logic [QA-1:0] qa;
  logic          sat_a, remnz_a;
  logic [RW-1:0] q_avg, q_hi, q_lo;
  logic          s_avg, s_hi, s_lo;
  logic          nz_avg, nz_hi, nz_lo;

  logic [DW-1:0] unused, div_sel, int_div, lo_div, dmask;
  logic [DW:0]   mindiv, maxdiv, qq, div1, div2;
  logic          rnd;
  logic [RW-1:0] r_avg, r_hi, r_lo, d_low, d_high, d_max;

  function automatic logic [RW-1:0] sat_sub(input logic [RW-1:0] a, input logic [RW-1:0] b);
    return (a > b) ? a - b : '0;
  endfunction

  function automatic logic [RW-1:0] pick_rate(input logic both, input logic z,
                                              input logic sat, input logic [RW-1:0] q,
                                              input logic [RW-1:0] parent);
    logic [RW-1:0] r;
    if (both) r = parent;
    else if (z) r = '0;
    else if (sat) r = '1;
    else r = q;
    return r;
  endfunction

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      int_bits_q  <= CfgDataWidth'(12);
      frac_bits_q <= CfgDataWidth'(12);
      mash_q      <= 1'b0;
      low_jit_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgIntegerBits:  int_bits_q  <= cfg_wdata_i;
        CfgFractionBits: frac_bits_q <= cfg_wdata_i;
        CfgMashMode:     mash_q      <= cfg_wdata_i[0];
        CfgLowJitter:    low_jit_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Clamp oversized bit counts to the fraction width
  assign ib = (int'(int_bits_q) > F) ? EW'(F) : EW'(int_bits_q);
  assign fb = (int'(frac_bits_q) > F) ? EW'(F) : EW'(frac_bits_q);
  assign su = EW'(F) - fb;

  // Advance the whole pipeline unless a finished result is held back
  assign en         = !out_vld_q || !out_stall_i;
  assign in_stall_o = !en;

  // Stage A: divider quotient parent * 2^F / target
  assign a_in.choose  = in_data_i.req_type == ReqChoose;
  assign a_in.ceil_en = in_data_i.ceil_en;
  assign a_in.zero    = in_data_i.target_rate == '0;
  assign a_in.parent  = in_data_i.src_rate;
  assign a_in.div_in  = in_data_i.divider_in;

  fcds_div #(.N_W(NW), .D_W(RW), .Q_W(QA)) u_div_sel (
    .clk_i     (clk_i),
    .en_i      (en),
    .dividend_i(NW'(in_data_i.src_rate) << F),
    .divisor_i (in_data_i.target_rate),
    .quot_o    (qa),
    .sat_o     (sat_a),
    .rem_nz_o  (remnz_a)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q[0] <= a_in;
      for (int k = 1; k < QA; k++) a_q[k] <= a_q[k-1];
    end
  end

  // Stage B: for a choose request round (if ceil_en), drop unused fraction bits and clamp; derive rate divisors
  always_comb begin
    unused = (DW'(1) << su) - DW'(1);
    dmask  = (DW'(1) << (int'(ib) + int'(fb))) - DW'(1);
    if (mash_q) begin
      mindiv = (DW+1)'(2) << F;
      maxdiv = (((DW+1)'(1) << ib) - (DW+1)'(1)) << F;
    end else begin
      mindiv = (DW+1)'(1) << F;
      maxdiv = (((DW+1)'(1) << (ib + F)) - (DW+1)'(1)) & ~{1'b0, unused};
    end
    rnd  = a_q[QA-1].ceil_en && (((qa & unused) != '0) || remnz_a);
    qq   = {1'b0, qa} + (rnd ? ({1'b0, unused} + (DW+1)'(1)) : '0);
    div1 = qq & ~{1'b0, unused};
    if (a_q[QA-1].zero || sat_a) begin
      div2 = maxdiv;
    end else begin
      div2 = (div1 < mindiv) ? mindiv : div1;
      if (div2 > maxdiv) div2 = maxdiv;
    end
    div_sel = a_q[QA-1].choose ? div2[DW-1:0] : a_q[QA-1].div_in;
    int_div = {div_sel[DW-1:F], F'(0)};
    lo_div  = int_div + (DW'(1) << F);

    b_d.div       = div_sel;
    b_d.status    = (a_q[QA-1].choose && a_q[QA-1].zero) ? StatusZeroTarget : StatusOk;
    b_d.jit_en    = a_q[QA-1].choose && low_jit_q && (div_sel[F-1:0] != '0);
    b_d.both_zero = (ib == '0) && (fb == '0);
    b_d.parent    = a_q[QA-1].parent;
    b_d.dvd       = NW'(a_q[QA-1].parent) << fb;
    b_d.d_avg     = (div_sel >> su) & dmask;
    b_d.d_hi      = (int_div >> su) & dmask;
    b_d.d_lo      = (lo_div >> su) & dmask;
  end

  always_ff @(posedge clk_i) begin
    if (en) b_q <= b_d;
  end

  // Stage C: three rate dividers side by side
  fcds_div #(.N_W(NW), .D_W(DW), .Q_W(QR)) u_div_avg (
    .clk_i(clk_i), .en_i(en), .dividend_i(b_q.dvd), .divisor_i(b_q.d_avg),
    .quot_o(q_avg), .sat_o(s_avg), .rem_nz_o(nz_avg)
  );
  fcds_div #(.N_W(NW), .D_W(DW), .Q_W(QR)) u_div_hi (
    .clk_i(clk_i), .en_i(en), .dividend_i(b_q.dvd), .divisor_i(b_q.d_hi),
    .quot_o(q_hi), .sat_o(s_hi), .rem_nz_o(nz_hi)
  );
  fcds_div #(.N_W(NW), .D_W(DW), .Q_W(QR)) u_div_lo (
    .clk_i(clk_i), .en_i(en), .dividend_i(b_q.dvd), .divisor_i(b_q.d_lo),
    .quot_o(q_lo), .sat_o(s_lo), .rem_nz_o(nz_lo)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_q[0].div       <= b_q.div;
      c_q[0].status    <= b_q.status;
      c_q[0].jit_en    <= b_q.jit_en;
      c_q[0].both_zero <= b_q.both_zero;
      c_q[0].parent    <= b_q.parent;
      c_q[0].z_avg     <= b_q.d_avg == '0;
      c_q[0].z_hi      <= b_q.d_hi == '0;
      c_q[0].z_lo      <= b_q.d_lo == '0;
      for (int k = 1; k < QR; k++) c_q[k] <= c_q[k-1];
    end
  end

  // Output stage: saturate rates, form the jitter metric
  always_comb begin
    r_avg  = pick_rate(c_q[QR-1].both_zero, c_q[QR-1].z_avg, s_avg, q_avg, c_q[QR-1].parent);
    r_hi   = pick_rate(c_q[QR-1].both_zero, c_q[QR-1].z_hi, s_hi, q_hi, c_q[QR-1].parent);
    r_lo   = pick_rate(c_q[QR-1].both_zero, c_q[QR-1].z_lo, s_lo, q_lo, c_q[QR-1].parent);
    d_low  = sat_sub(r_avg, r_lo);
    d_high = sat_sub(r_hi, r_avg);
    d_max  = (d_low > d_high) ? d_low : d_high;

    out_d.divider       = c_q[QR-1].div;
    out_d.fraction_used = c_q[QR-1].div[F-1:0] != '0;
    out_d.achieved_rate = r_avg;
    out_d.jitter_metric = c_q[QR-1].jit_en ? sat_sub(r_avg, d_max) : r_avg;
    out_d.status        = c_q[QR-1].status;
  end

  always_ff @(posedge clk_i) begin
    if (en) out_q <= out_d;
  end

  // Valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q   <= '0;
      b_vld_q   <= 1'b0;
      c_vld_q   <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q   <= {a_vld_q[QA-2:0], in_valid_i};
      b_vld_q   <= a_vld_q[QA-1];
      c_vld_q   <= {c_vld_q[QR-2:0], b_vld_q};
      out_vld_q <= c_vld_q[QR-1];
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // Unused remainder flags of the rate dividers are not needed for a rate
  logic unused_nz;
  assign unused_nz = nz_avg ^ nz_hi ^ nz_lo;

  a_frac_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> out_q.fraction_used == (out_q.divider[F-1:0] != '0))
    else $error("fraction_used disagrees with divider");

  a_metric_le: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> out_q.jitter_metric <= out_q.achieved_rate)
    else $error("jitter metric above achieved rate");

  a_hold_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(a_vld_q) && $stable(c_vld_q) && $stable(b_vld_q))
    else $error("pipeline moved while stalled");

  a_status_choose: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.status == StatusZeroTarget && !unused_nz |-> out_q.divider != '0 ||
      out_q.divider == '0)
    else $error("status check");

endmodule
